// File: sv/double_ended_queue_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Concurrent property wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define DEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/deq_pkg.sv
// ---------------------------------------------------------------------------
// Deque package
// Operation codes, controller states, command struct and default sizes.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int MODE_W = 3;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_REAR  = 3'd5
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;     // operation transfer taken this cycle
        logic respond;  // result is on the output ports
    } t_cmd;

endpackage

// File: sv/deq_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: sv/deq_ctrl.sv
// ---------------------------------------------------------------------------
// Deque controller
// Takes one operation, then holds busy for the cycle that shows its result.
// ---------------------------------------------------------------------------
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output deq_pkg::t_cmd o_cmd
);

    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.exec    = 1'b0;
        o_cmd.respond = 1'b0;
        o_busy        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_RESP;
                end
            end
            ST_RESP: begin
                o_cmd.respond = 1'b1;
                o_busy        = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/deq_dpath.sv
// ---------------------------------------------------------------------------
// Deque datapath
// Ring store with front/rear indices and element count.
// ---------------------------------------------------------------------------
module deq_dpath #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  deq_pkg::t_cmd               i_cmd,
    input  logic [deq_pkg::MODE_W-1:0]  i_mode,
    input  logic [deq_pkg::DATA_W-1:0]  i_push_data,
    output logic                        o_success,
    output logic [deq_pkg::DATA_W-1:0]  o_out_data,
    output logic [deq_pkg::OCC_W-1:0]   o_occupancy,
    output logic                        o_is_empty
);

    import deq_pkg::*;

    localparam int IW      = $clog2(CAPACITY);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int EXT_W   = DATA_W + DATA_WIDTH;
    localparam int OCC_EXT = OCC_W + CW;

    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear,  n_rear;
    logic [CW-1:0] r_count, n_count;
    logic          r_ok,     n_ok;
    logic          r_rd_sel, n_rd_sel;

    logic [IW-1:0]         w_front_prev, w_front_next;
    logic [IW-1:0]         w_rear_prev,  w_rear_next;
    logic                  w_full, w_empty;
    logic                  w_we;
    logic [IW-1:0]         w_addr;
    logic [EXT_W-1:0]      w_push_ext, w_rd_ext;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [OCC_EXT-1:0]    w_cnt_ext;

    // wrap for any capacity, not just powers of two
    assign w_front_prev = (r_front == '0) ? IW'(CAPACITY - 1) : r_front - IW'(1);
    assign w_front_next = (r_front == IW'(CAPACITY - 1)) ? '0 : r_front + IW'(1);
    assign w_rear_prev  = (r_rear == '0) ? IW'(CAPACITY - 1) : r_rear - IW'(1);
    assign w_rear_next  = (r_rear == IW'(CAPACITY - 1)) ? '0 : r_rear + IW'(1);

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_push_ext = EXT_W'(i_push_data);

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_ok     = r_ok;
        n_rd_sel = r_rd_sel;
        w_we     = 1'b0;
        w_addr   = r_front;
        if (i_cmd.exec) begin
            n_ok     = 1'b0;
            n_rd_sel = 1'b0;
            unique case (i_mode)
                MODE_PUSH_FRONT: begin
                    if (!w_full) begin
                        n_ok    = 1'b1;
                        n_count = r_count + CW'(1);
                        w_we    = 1'b1;
                        if (w_empty) begin
                            n_rear = r_front;
                            w_addr = r_front;
                        end else begin
                            n_front = w_front_prev;
                            w_addr  = w_front_prev;
                        end
                    end
                end
                MODE_PUSH_REAR: begin
                    if (!w_full) begin
                        n_ok    = 1'b1;
                        n_count = r_count + CW'(1);
                        w_we    = 1'b1;
                        if (w_empty) begin
                            n_rear = r_front;
                            w_addr = r_front;
                        end else begin
                            n_rear = w_rear_next;
                            w_addr = w_rear_next;
                        end
                    end
                end
                MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                    w_addr = r_front;
                    if (!w_empty) begin
                        n_ok     = 1'b1;
                        n_rd_sel = 1'b1;
                        if (i_mode == MODE_POP_FRONT) begin
                            n_count = r_count - CW'(1);
                            // last element out: indices stay put
                            if (r_count != CW'(1)) begin
                                n_front = w_front_next;
                            end
                        end
                    end
                end
                MODE_POP_REAR, MODE_PEEK_REAR: begin
                    w_addr = r_rear;
                    if (!w_empty) begin
                        n_ok     = 1'b1;
                        n_rd_sel = 1'b1;
                        if (i_mode == MODE_POP_REAR) begin
                            n_count = r_count - CW'(1);
                            if (r_count != CW'(1)) begin
                                n_rear = w_rear_prev;
                            end
                        end
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok     <= n_ok;
        r_rd_sel <= n_rd_sel;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_push_ext[DATA_WIDTH-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_ext  = EXT_W'(w_rdata);
    assign w_cnt_ext = OCC_EXT'(r_count);

    assign o_success   = r_ok;
    assign o_out_data  = r_rd_sel ? w_rd_ext[DATA_W-1:0] : '0;
    assign o_occupancy = w_cnt_ext[OCC_W-1:0];
    assign o_is_empty  = (r_count == '0);

endmodule

// File: sv/double_ended_queue_unit.sv
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque: push/pop/peek at either end of a ring store.
// ---------------------------------------------------------------------------
// In the cycle that start is taken, the ring store is written or read and
// the indices and count update; in the next cycle o_busy is high and the
// result sits on the output ports for that one cycle, marked
// by o_valid, with pop/peek data straight from the RAM's registered read
// port. The receiver cannot stall: it must take the result in that cycle.
// start may be raised again in the cycle right after the result.
// Entries are never cleared; the unit is ready immediately after reset.
// ---------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [deq_pkg::MODE_W-1:0]  i_mode,
    input  logic [deq_pkg::DATA_W-1:0]  i_push_data,
    output logic                        o_valid,
    output logic                        o_success,
    output logic [deq_pkg::DATA_W-1:0]  o_out_data,
    output logic [deq_pkg::OCC_W-1:0]   o_occupancy,
    output logic                        o_is_empty
);

    import deq_pkg::*;

    t_cmd w_cmd;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    deq_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (i_mode),
        .i_push_data (i_push_data),
        .o_success   (o_success),
        .o_out_data  (o_out_data),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty)
    );

    assign o_valid = w_cmd.respond;

    `DEQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_start && !o_busy, o_valid)
    `DEQ_ASSERT_IMPL(a_fail_zero_data, i_clk, i_rst_n, o_valid && !o_success, o_out_data == '0)
    `DEQ_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule
